/* sv/fdcsep_pkg.sv */
// ----------------------------------------------------------------------------
// fdcsep_pkg
// Shared types, widths and constants of the data separator VFO.
// ----------------------------------------------------------------------------
package fdcsep_pkg;

  localparam int HistLen   = 8;
  localparam int WeightSum = HistLen * (HistLen + 1) / 2;
  localparam int HistCntW  = $clog2(HistLen);
  localparam int PosW      = 16;
  localparam int RunW      = PosW + $clog2(HistLen) + 1;
  localparam int TotW      = PosW + $clog2(WeightSum) + 1;
  localparam int AvgW      = 17;

  // average: (sum + WeightSum/2) * AvgRecip >> AvgShift
  localparam int          AvgShift = 27;
  localparam logic [21:0] AvgRecip = 22'd3728271;

  // size bounds: 5*ref/7 and 7*ref/5 by reciprocal
  localparam int          BoundShift = 20;
  localparam logic [17:0] LoRecip    = 18'd149797;
  localparam logic [17:0] HiRecip    = 18'd209716;

  localparam int DivW    = 32;
  localparam int DenW    = 19;
  localparam int DivCntW = $clog2(DivW);

  localparam logic [17:0] UnwrapMargin = 18'd282;

  localparam logic [13:0] RefReset   = 14'd2048;
  localparam logic [15:0] PropReset  = 16'd16384;
  localparam logic [15:0] IntegReset = 16'd1024;
  localparam logic [15:0] DerivReset = 16'd4096;
  localparam logic [15:0] GainReset  = 16'd4096;

  localparam logic OpPulse   = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef enum logic [2:0] {
    CfgRef   = 3'd0,
    CfgProp  = 3'd1,
    CfgInteg = 3'd2,
    CfgDeriv = 3'd3,
    CfgGain  = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WALK, ST_AVG, ST_ERR, ST_LIM_GO, ST_LIM_WAIT,
    ST_INTEG, ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_SUM, ST_MUL_LO, ST_MUL_HI,
    ST_COMB, ST_ROUND, ST_LO, ST_HI, ST_CLAMP,
    ST_OUT
  } fsm_state_e;

  typedef struct packed {
    logic fill;
    logic shift;
    logic rot;
  } cell_ctl_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/fdcsep_if.sv */
// ----------------------------------------------------------------------------
// fdcsep interfaces
// Pulse, result and configuration channels of the data separator VFO.
// ----------------------------------------------------------------------------
interface fdcsep_pulse_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [14:0] pulse_position;
  modport source (output valid, op, pulse_position, input ready);
  modport sink (input valid, op, pulse_position, output ready);
endinterface

interface fdcsep_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] pulse_echo;
  logic [14:0] cell_size;
  logic [13:0] cell_center;
  logic        integral_clamped;
  logic        size_clamped;
  modport source (output valid, pulse_echo, cell_size, cell_center, integral_clamped,
                  size_clamped, input ready);
  modport sink (input valid, pulse_echo, cell_size, cell_center, integral_clamped,
                size_clamped, output ready);
endinterface

interface fdcsep_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/fdcsep_cell.sv */
// ----------------------------------------------------------------------------
// fdcsep_cell
// One history cell: holds a position, loads, shifts or rotates by neighbor.
// ----------------------------------------------------------------------------
module fdcsep_cell import fdcsep_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic signed [PosW-1:0] fill_i,
  input  logic signed [PosW-1:0] left_i,
  input  logic signed [PosW-1:0] right_i,
  output logic signed [PosW-1:0] val_o
);

  logic signed [PosW-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= PosW'(RefReset >> 1);
    end else if (ctl_i.fill) begin
      val_q <= fill_i;
    end else if (ctl_i.shift) begin
      val_q <= left_i;
    end else if (ctl_i.rot) begin
      val_q <= right_i;
    end
  end

  assign val_o = val_q;

endmodule

/* sv/fdcsep_div.sv */
// ----------------------------------------------------------------------------
// fdcsep_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdcsep_div import fdcsep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    num_q;
  logic [DenW-1:0]    rem_q;
  logic [DenW-1:0]    den_q;
  logic [DenW:0]      rem_sh;
  logic               qbit;
  logic [DenW:0]      rem_sub;

  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign qbit    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.dividend;
        den_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= {num_q[DivW-2:0], qbit};
        rem_q <= qbit ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

/* sv/fdc_data_separator_pid_vfo_unit.sv */
// ----------------------------------------------------------------------------
// fdc_data_separator_pid_vfo_unit
// Floppy data separator VFO with PID steered bit cell size.
// ----------------------------------------------------------------------------
// Usage:
//   pulse_i : one item per flux pulse, op selects pulse sample or restart.
//   res_o   : one item per pulse item: echo, new cell size, its half, flags.
//   cfg_i   : register writes (index, data), always ready; write only while idle.
// Sequence: a pulse sample, once taken, rotates the history chain; the
//   sequencer forms the average and error, waits on the 32-step divider for
//   the integral limit and steps through the integral, PID, rounding and
//   size clamp states to the output state, where its result is loaded. The
//   next item is taken from the cycle after that. A restart item goes from
//   idle straight to the output state. One item is in work at a time.
// Reset: registers take their default values, the history holds half the
//   reference cell size, loop state is cleared.
// Stall: the result register holds while res_o.ready is low; a new item is
//   still taken, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module fdc_data_separator_pid_vfo_unit import fdcsep_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  fdcsep_pulse_if.sink  pulse_i,
  fdcsep_res_if.source  res_o,
  fdcsep_cfg_if.sink    cfg_i
);

  fsm_state_e state_q, state_d;

  logic [13:0] ref_q;
  logic [15:0] prop_q, ki_q, kd_q, gain_q;
  logic [15:0] ki_eff;

  logic        in_acc;
  logic [14:0] raw_q;
  logic [14:0] prev_pos_q;
  logic [14:0] cur_q;

  logic [HistCntW-1:0]    cnt_q;
  logic signed [RunW-1:0] s_q, s_d;
  logic signed [TotW-1:0] t_q, t_d;
  logic [TotW-1:0]        t_mag;
  logic [21:0]            avg_num;
  logic [43:0]            avg_prod;

  logic signed [AvgW-1:0] avg_q;
  logic signed [17:0]     errp_q, prev_err_q, errp_sat;
  logic signed [18:0]     errd_q, err_diff;
  logic signed [29:0]     integ_q;
  logic signed [30:0]     integ_sum, lim_s;
  logic [28:0]            lim_q;
  logic                   iflag_q, sflag_q;

  logic signed [34:0] p_q;
  logic signed [35:0] d_q;
  logic signed [46:0] i_q;
  logic signed [47:0] acc_q;
  logic [39:0]        mlo_q;
  logic signed [41:0] mhi_q;
  logic signed [64:0] big_q;
  logic [64:0]        big_mag;
  logic [64:0]        big_rnd;
  logic signed [37:0] corr_q;
  logic signed [38:0] new_size;
  logic [14:0]        lo_q, hi_q;
  logic [16:0]        ref5, ref7;
  logic [34:0]        lo_prod, hi_prod;

  logic signed [17:0] thr, pos_w;
  logic signed [PosW-1:0] pos_sat;

  logic        res_valid_q;
  logic [14:0] res_echo_q, res_size_q;
  logic [13:0] res_center_q;
  logic        res_if_q, res_sf_q;

  cell_ctl_t              cell_ctl;
  logic signed [PosW-1:0] cell_val [HistLen];
  logic signed [PosW-1:0] fill_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc      = pulse_i.valid && pulse_i.ready;
  assign cfg_i.ready = 1'b1;
  assign ki_eff      = (ki_q == '0) ? 16'd1 : ki_q;
  assign fill_val    = PosW'(ref_q >> 1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= RefReset;
      prop_q <= PropReset;
      ki_q   <= IntegReset;
      kd_q   <= DerivReset;
      gain_q <= GainReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgRef:   ref_q  <= cfg_i.data[13:0];
        CfgProp:  prop_q <= cfg_i.data;
        CfgInteg: ki_q   <= cfg_i.data;
        CfgDeriv: kd_q   <= cfg_i.data;
        CfgGain:  gain_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // history chain: cell 0 holds the newest entry
  for (genvar k = 0; k < HistLen; k++) begin : g_chain
    localparam int Nx = (k + 1) % HistLen;
    logic signed [PosW-1:0] left;
    if (k == 0) begin : g_head
      assign left = pos_sat;
    end else begin : g_body
      assign left = cell_val[k-1];
    end
    fdcsep_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .fill_i (fill_val),
      .left_i (left),
      .right_i(cell_val[Nx]),
      .val_o  (cell_val[k])
    );
  end

  fdcsep_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // unwrap of the incoming position
  always_comb begin
    thr   = $signed({3'b0, cur_q}) - $signed(UnwrapMargin);
    pos_w = $signed({3'b0, pulse_i.pulse_position});
    if (prev_pos_q > pulse_i.pulse_position) begin
      if ($signed({3'b0, prev_pos_q}) - $signed({3'b0, pulse_i.pulse_position}) > thr) begin
        pos_w = pos_w + $signed({3'b0, cur_q});
      end
    end else if (pulse_i.pulse_position > prev_pos_q) begin
      if ($signed({3'b0, pulse_i.pulse_position}) - $signed({3'b0, prev_pos_q}) > thr) begin
        pos_w = pos_w - $signed({3'b0, cur_q});
      end
    end
    if (pos_w > 18'sd32767) begin
      pos_sat = 16'sh7FFF;
    end else if (pos_w < -18'sd32768) begin
      pos_sat = 16'sh8000;
    end else begin
      pos_sat = pos_w[15:0];
    end
  end

  assign s_d   = s_q + RunW'(cell_val[0]);
  assign t_d   = t_q + TotW'(s_d);
  assign t_mag = t_q[TotW-1] ? TotW'(-t_q) : TotW'(t_q);

  // rounded magnitude of the weighted average
  assign avg_num  = t_mag[21:0] + 22'(WeightSum / 2);
  assign avg_prod = 44'(avg_num) * 44'(AvgRecip);

  always_comb begin
    err_diff = $signed({5'b0, cur_q[14:1]}) - 19'(avg_q);
    if (err_diff > 19'sd131071) begin
      errp_sat = 18'sh1FFFF;
    end else if (err_diff < -19'sd131072) begin
      errp_sat = 18'sh20000;
    end else begin
      errp_sat = err_diff[17:0];
    end
  end

  assign integ_sum = 31'(integ_q) + 31'(errp_q);
  assign lim_s     = $signed({2'b0, lim_q});
  assign big_mag   = big_q[64] ? 65'(-big_q) : 65'(big_q);
  assign big_rnd   = big_mag + (65'd1 << 27);
  assign new_size  = $signed({25'b0, ref_q}) - 39'(corr_q);

  // cell size bounds
  assign ref5    = (17'(ref_q) << 2) + 17'(ref_q);
  assign ref7    = (17'(ref_q) << 3) - 17'(ref_q);
  assign lo_prod = 35'(ref5) * 35'(LoRecip);
  assign hi_prod = 35'(ref7) * 35'(HiRecip);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc) state_d = (pulse_i.op == OpRestart) ? ST_OUT : ST_WALK;
      ST_WALK:     if (cnt_q == HistCntW'(HistLen - 1)) state_d = ST_AVG;
      ST_AVG:      state_d = ST_ERR;
      ST_ERR:      state_d = ST_LIM_GO;
      ST_LIM_GO:   state_d = ST_LIM_WAIT;
      ST_LIM_WAIT: if (div_rsp.done) state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_MUL_P;
      ST_MUL_P:    state_d = ST_MUL_D;
      ST_MUL_D:    state_d = ST_MUL_I;
      ST_MUL_I:    state_d = ST_SUM;
      ST_SUM:      state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_COMB;
      ST_COMB:     state_d = ST_ROUND;
      ST_ROUND:    state_d = ST_LO;
      ST_LO:       state_d = ST_HI;
      ST_HI:       state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_OUT;
      ST_OUT:      if (!res_valid_q || res_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pulse_i.ready    = 1'b0;
    cell_ctl         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      ST_IDLE: begin
        pulse_i.ready  = 1'b1;
        cell_ctl.fill  = in_acc && (pulse_i.op == OpRestart);
        cell_ctl.shift = in_acc && (pulse_i.op == OpPulse);
      end
      ST_WALK: cell_ctl.rot = 1'b1;
      ST_LIM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivW'({ref_q, 17'b0});
        div_req.divisor  = ({3'b0, ki_eff} << 2) + {3'b0, ki_eff};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      raw_q        <= '0;
      prev_pos_q   <= '0;
      cur_q        <= 15'(RefReset);
      cnt_q        <= '0;
      s_q          <= '0;
      t_q          <= '0;
      avg_q        <= '0;
      errp_q       <= '0;
      errd_q       <= '0;
      prev_err_q   <= '0;
      integ_q      <= '0;
      lim_q        <= '0;
      iflag_q      <= 1'b0;
      sflag_q      <= 1'b0;
      p_q          <= '0;
      d_q          <= '0;
      i_q          <= '0;
      acc_q        <= '0;
      mlo_q        <= '0;
      mhi_q        <= '0;
      big_q        <= '0;
      corr_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      res_valid_q  <= 1'b0;
      res_echo_q   <= '0;
      res_size_q   <= '0;
      res_center_q <= '0;
      res_if_q     <= 1'b0;
      res_sf_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_o.ready && state_q != ST_OUT) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (in_acc) begin
          raw_q   <= pulse_i.pulse_position;
          iflag_q <= 1'b0;
          sflag_q <= 1'b0;
          if (pulse_i.op == OpRestart) begin
            prev_pos_q <= '0;
            prev_err_q <= '0;
            integ_q    <= '0;
          end else begin
            prev_pos_q <= pulse_i.pulse_position;
            cnt_q      <= '0;
            s_q        <= '0;
            t_q        <= '0;
          end
        end
        ST_WALK: begin
          s_q   <= s_d;
          t_q   <= t_d;
          cnt_q <= cnt_q + 1'b1;
        end
        ST_AVG: begin
          avg_q <= t_q[TotW-1] ? -$signed(avg_prod[AvgShift +: AvgW])
                               : $signed(avg_prod[AvgShift +: AvgW]);
        end
        ST_ERR: begin
          errp_q     <= errp_sat;
          errd_q     <= 19'(errp_sat) - 19'(prev_err_q);
          prev_err_q <= errp_sat;
        end
        ST_LIM_WAIT: if (div_rsp.done) lim_q <= div_rsp.quot[28:0];
        ST_INTEG: begin
          if (integ_sum > lim_s) begin
            integ_q <= lim_s[29:0];
            iflag_q <= 1'b1;
          end else if (integ_sum < -lim_s) begin
            integ_q <= 30'(-lim_s);
            iflag_q <= 1'b1;
          end else begin
            integ_q <= integ_sum[29:0];
          end
        end
        ST_MUL_P:  p_q   <= errp_q * $signed({1'b0, prop_q});
        ST_MUL_D:  d_q   <= errd_q * $signed({1'b0, kd_q});
        ST_MUL_I:  i_q   <= integ_q * $signed({1'b0, ki_eff});
        ST_SUM:    acc_q <= 48'(p_q) - 48'(d_q) + 48'(i_q);
        ST_MUL_LO: mlo_q <= 40'(acc_q[22:0]) * 40'(gain_q);
        ST_MUL_HI: mhi_q <= $signed(acc_q[47:23]) * $signed({1'b0, gain_q});
        ST_COMB:   big_q <= (65'(mhi_q) <<< 23) + $signed({25'b0, mlo_q});
        ST_ROUND:  corr_q <= big_q[64] ? -$signed({1'b0, big_rnd[64:28]})
                                       : $signed({1'b0, big_rnd[64:28]});
        ST_LO:     lo_q <= lo_prod[BoundShift +: 15];
        ST_HI:     hi_q <= hi_prod[BoundShift +: 15];
        ST_CLAMP: begin
          if (new_size < $signed({24'b0, lo_q})) begin
            cur_q   <= lo_q;
            sflag_q <= 1'b1;
          end else if (new_size > $signed({24'b0, hi_q})) begin
            cur_q   <= hi_q;
            sflag_q <= 1'b1;
          end else begin
            cur_q <= new_size[14:0];
          end
        end
        ST_OUT: if (!res_valid_q || res_o.ready) begin
          res_valid_q  <= 1'b1;
          res_echo_q   <= raw_q;
          res_size_q   <= cur_q;
          res_center_q <= cur_q[14:1];
          res_if_q     <= iflag_q;
          res_sf_q     <= sflag_q;
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.pulse_echo       = res_echo_q;
  assign res_o.cell_size        = res_size_q;
  assign res_o.cell_center      = res_center_q;
  assign res_o.integral_clamped = res_if_q;
  assign res_o.size_clamped     = res_sf_q;

`ifndef SYNTHESIS
  a_center_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.cell_center == res_o.cell_size[14:1])
    else $error("cell center is not half the cell size");

  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_P |-> (31'(integ_q) <= lim_s) && (31'(integ_q) >= -lim_s))
    else $error("integral outside its limit");

  a_walk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> cnt_q <= HistCntW'(HistLen - 1))
    else $error("history walk overran");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pulse_i.op == OpRestart) |=> state_q == ST_OUT && integ_q == '0 && !iflag_q)
    else $error("restart did not clear loop state");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the data separator VFO against a cycle-free predictor of its loop:
// unwrap, weighted history average, PID correction, integral and size clamps.
// Directed register extremes, restarts and wrap cases, then random pulse
// trains with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import fdcsep_pkg::*;

  typedef struct packed {
    logic [14:0] echo;
    logic [14:0] size;
    logic [13:0] center;
    logic        iclamp;
    logic        sclamp;
  } vfo_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fails = 0;
  bit   stall_en = 1'b0;

  fdcsep_pulse_if pulse();
  fdcsep_res_if   res();
  fdcsep_cfg_if   cfg();

  fdc_data_separator_pid_vfo_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pulse_i(pulse), .res_o(res), .cfg_i(cfg)
  );

  // predictor state
  longint m_ref, m_prop, m_integ, m_deriv, m_gain;
  longint m_hist[HistLen];
  int     m_ptr;
  longint m_prev_pos, m_prev_err, m_integral, m_size;
  vfo_res_t expected_q[$];

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void loop_restart();
    for (int i = 0; i < HistLen; i++) m_hist[i] = m_ref >> 1;
    m_prev_pos = 0;
    m_prev_err = 0;
    m_integral = 0;
  endfunction

  function automatic vfo_res_t predict_cell(logic op, logic [14:0] raw_pos);
    vfo_res_t r;
    longint pos, thr, sum, avg, errp, errd, lim, acc, corr, nsz, lo, hi, ki;
    r = '0;
    r.echo = raw_pos;
    if (op == OpRestart) begin
      loop_restart();
      r.size = m_size[14:0];
      r.center = m_size[14:1];
      return r;
    end
    ki = (m_integ == 0) ? 1 : m_integ;
    pos = raw_pos;
    thr = m_size - 282;
    if (m_prev_pos > pos) begin
      if (m_prev_pos - pos > thr) pos += m_size;
    end else if (pos > m_prev_pos) begin
      if (pos - m_prev_pos > thr) pos -= m_size;
    end
    pos = clip(pos, -32768, 32767);
    m_ptr = (m_ptr + 1) % HistLen;
    m_hist[m_ptr] = pos;
    sum = 0;
    for (int i = 1; i <= HistLen; i++) sum += m_hist[(m_ptr + i) % HistLen] * i;
    avg = round_half_away(sum, WeightSum);
    errp = clip(m_size / 2 - avg, -131072, 131071);
    errd = errp - m_prev_err;
    m_prev_err = errp;
    lim = (m_ref * 2 * 65536) / (5 * ki);
    m_integral += errp;
    if (m_integral > lim) begin
      m_integral = lim;
      r.iclamp = 1'b1;
    end else if (m_integral < -lim) begin
      m_integral = -lim;
      r.iclamp = 1'b1;
    end
    acc = (errp * m_prop - errd * m_deriv + m_integral * ki) * m_gain;
    corr = round_half_away(acc, 64'sd1 << 28);
    nsz = m_ref - corr;
    lo = (m_ref * 5) / 7;
    hi = (m_ref * 7) / 5;
    if (nsz < lo) begin
      nsz = lo;
      r.sclamp = 1'b1;
    end else if (nsz > hi) begin
      nsz = hi;
      r.sclamp = 1'b1;
    end
    m_size = nsz;
    m_prev_pos = raw_pos;
    r.size = nsz[14:0];
    r.center = nsz[14:1];
    return r;
  endfunction

  // receiver: stall pattern and result check
  always @(posedge clk_i) begin
    vfo_res_t got, exp_r;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.pulse_echo, res.cell_size, res.cell_center,
              res.integral_clamped, res.size_clamped};
      if (expected_q.size() == 0) begin
        $error("result with none expected");
        fails++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.echo !== exp_r.echo) begin
          $error("pulse_echo exp %0d got %0d", exp_r.echo, got.echo); fails++;
        end
        if (got.size !== exp_r.size) begin
          $error("cell_size exp %0d got %0d", exp_r.size, got.size); fails++;
        end
        if (got.center !== exp_r.center) begin
          $error("cell_center exp %0d got %0d", exp_r.center, got.center); fails++;
        end
        if (got.iclamp !== exp_r.iclamp) begin
          $error("integral_clamped exp %0b got %0b", exp_r.iclamp, got.iclamp);
          fails++;
        end
        if (got.sclamp !== exp_r.sclamp) begin
          $error("size_clamped exp %0b got %0b", exp_r.sclamp, got.sclamp);
          fails++;
        end
      end
    end
    res.ready <= stall_en ? (((cycles / 37) % 3 == 0) ? 1'b0 : $urandom_range(0, 3) != 0)
                          : 1'b1;
  end

  task automatic send_item(logic op, logic [14:0] p);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    pulse.valid <= 1'b1;
    pulse.op <= op;
    pulse.pulse_position <= p;
    do @(posedge clk_i); while (!pulse.ready);
    expected_q.push_back(predict_cell(op, p));
    pulse.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CfgRef:   m_ref = val[13:0];
      CfgProp:  m_prop = val;
      CfgInteg: m_integ = val;
      CfgDeriv: m_deriv = val;
      CfgGain:  m_gain = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic pulse_train(int n, int jitter);
    logic [14:0] p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) p = 15'($urandom_range(0, 32767));
      else p = 15'(clip(longint'(m_size / 2) + $urandom_range(0, 2 * jitter) - jitter,
                        0, 32767));
      send_item($urandom_range(0, 30) == 0 ? OpRestart : OpPulse, p);
    end
  endtask

  task automatic test_directed();
    send_item(OpPulse, 15'd0);
    send_item(OpPulse, 15'h7FFF);
    send_item(OpPulse, 15'd0);
    send_item(OpPulse, 15'd1024);
    send_item(OpRestart, 15'h7FFF);
    send_item(OpPulse, 15'd1900);
    send_item(OpPulse, 15'd100);
    send_item(OpPulse, 15'h5555);
    send_item(OpPulse, 15'h2AAA);
    send_item(OpRestart, 15'd0);
    drain();
  endtask

  task automatic test_reg_extremes();
    write_reg(CfgRef, 16'd16383);
    write_reg(CfgProp, 16'hFFFF);
    write_reg(CfgInteg, 16'd0);
    write_reg(CfgDeriv, 16'hFFFF);
    write_reg(CfgGain, 16'hFFFF);
    send_item(OpRestart, 15'd5);
    for (int i = 0; i < 6; i++) send_item(OpPulse, i[0] ? 15'h7FFF : 15'd0);
    drain();
    write_reg(CfgRef, 16'd256);
    write_reg(CfgProp, 16'd1);
    write_reg(CfgInteg, 16'hFFFF);
    write_reg(CfgDeriv, 16'd0);
    write_reg(CfgGain, 16'd0);
    send_item(OpRestart, 15'd0);
    for (int i = 0; i < 5; i++) send_item(OpPulse, 15'(300 * i));
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgRef, ph == 0 ? 16'd2048 : 16'($urandom_range(256, 16383)));
      write_reg(CfgProp, 16'($urandom_range(1, 65535)));
      write_reg(CfgInteg, ph[0] ? 16'($urandom_range(1, 4096))
                                : 16'($urandom_range(1, 65535)));
      write_reg(CfgDeriv, 16'($urandom_range(0, 65535)));
      write_reg(CfgGain, ph[1] ? 16'($urandom_range(0, 8192))
                               : 16'($urandom_range(0, 65535)));
      send_item(OpRestart, 15'($urandom_range(0, 32767)));
      stall_en = ph[0] | ph[2];
      pulse_train(48, ph < 4 ? 64 : 2048);
      drain();
    end
  endtask

  initial begin
    pulse.valid = 1'b0;
    pulse.op = OpPulse;
    pulse.pulse_position = '0;
    cfg.valid = 1'b0;
    cfg.index = CfgRef;
    cfg.data = '0;
    m_ref = RefReset;
    m_prop = PropReset;
    m_integ = IntegReset;
    m_deriv = DerivReset;
    m_gain = GainReset;
    loop_restart();
    m_ptr = 0;
    m_size = RefReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reg_extremes();
    test_random();
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* fdc_data_separator_pid_vfo_unit.f */
sv/fdcsep_pkg.sv
sv/fdcsep_if.sv
sv/fdcsep_cell.sv
sv/fdcsep_div.sv
sv/fdc_data_separator_pid_vfo_unit.sv
bench/tb.sv
